FILE: hw/rtl/tsfc_pkg.sv
// ----------------------------------------------------------------------------
// tsfc_pkg
// Widths shared by the triangle shape-function coefficient pipeline.
// ----------------------------------------------------------------------------
package tsfc_pkg;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned CRD_W   = 16;
    localparam int unsigned DIF_W   = CRD_W + 1;
    localparam int unsigned PRD_W   = 2 * CRD_W;
    localparam int unsigned CRS_W   = PRD_W + 1;
    localparam int unsigned AREA_W  = CRS_W + 2;
    localparam int unsigned NUM_W   = 49;
    localparam int unsigned DEN_W   = 34;
    localparam int unsigned REM_W   = DEN_W + 1;
    localparam int unsigned NSTEP   = 33;
    localparam int unsigned COEF_W  = 32;
    localparam int unsigned NLANE   = 9;
    localparam int unsigned DSHIFT  = 24;
    localparam int unsigned CSHIFT  = 16;

    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

FILE: hw/rtl/triangle_shape_function_coeffs.sv
// ----------------------------------------------------------------------------
// triangle_shape_function_coeffs
// Linear triangle shape-function coefficients, one element per beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with elem_tag and three Q8.8 vertices.
// Output channel: out_valid / out_stall with the tag, nine Q16.16 coefficients
// and a degenerate flag (zero area, coefficients then zero).
// Three stages form products, cross products and twice the area, 33
// restoring-division stages (nine lanes sharing one divisor) produce one
// quotient bit each, and one stage applies sign and saturation. Throughput
// is one beat per cycle unless stalled. The whole pipeline moves on one
// enable; when a result is held by out_stall the pipeline freezes and
// in_stall is raised, nothing is dropped or repeated. Reset clears all
// valid bits, so in_stall is low and the block takes beats right after reset.
// ----------------------------------------------------------------------------
module triangle_shape_function_coeffs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tsfc_pkg::TAG_W-1:0]          elem_tag,
    input  logic signed [tsfc_pkg::CRD_W-1:0]   x1,
    input  logic signed [tsfc_pkg::CRD_W-1:0]   y1,
    input  logic signed [tsfc_pkg::CRD_W-1:0]   x2,
    input  logic signed [tsfc_pkg::CRD_W-1:0]   y2,
    input  logic signed [tsfc_pkg::CRD_W-1:0]   x3,
    input  logic signed [tsfc_pkg::CRD_W-1:0]   y3,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tsfc_pkg::TAG_W-1:0]          elem_tag_out,
    output logic signed [tsfc_pkg::COEF_W-1:0]  grad_x_one,
    output logic signed [tsfc_pkg::COEF_W-1:0]  grad_y_one,
    output logic signed [tsfc_pkg::COEF_W-1:0]  offset_one,
    output logic signed [tsfc_pkg::COEF_W-1:0]  grad_x_two,
    output logic signed [tsfc_pkg::COEF_W-1:0]  grad_y_two,
    output logic signed [tsfc_pkg::COEF_W-1:0]  offset_two,
    output logic signed [tsfc_pkg::COEF_W-1:0]  grad_x_three,
    output logic signed [tsfc_pkg::COEF_W-1:0]  grad_y_three,
    output logic signed [tsfc_pkg::COEF_W-1:0]  offset_three,
    output logic                                degenerate
);
    import tsfc_pkg::*;

    logic en;

    // stage 1
    logic                     v1_reg;
    logic [TAG_W-1:0]         tag1_reg;
    logic signed [PRD_W-1:0]  prd_reg [0:5];
    logic signed [DIF_W-1:0]  dif1_reg [0:5];
    // stage 2
    logic                     v2_reg;
    logic [TAG_W-1:0]         tag2_reg;
    logic signed [CRS_W-1:0]  crs_reg [0:2];
    logic signed [DIF_W-1:0]  dif2_reg [0:5];
    // divider stages
    logic                     vd_reg   [0:NSTEP];
    logic [TAG_W-1:0]         tagd_reg [0:NSTEP];
    logic                     degd_reg [0:NSTEP];
    logic [DEN_W-1:0]         den_reg  [0:NSTEP];
    logic [NLANE-1:0]         neg_reg  [0:NSTEP];
    logic [NLANE-1:0]         ovf_reg  [0:NSTEP];
    logic [REM_W-1:0]         rem_reg  [0:NSTEP][0:NLANE-1];
    logic [NSTEP-1:0]         sh_reg   [0:NSTEP][0:NLANE-1];
    logic [NSTEP-1:0]         quo_reg  [0:NSTEP][0:NLANE-1];
    // output
    logic                     vo_reg;
    logic [TAG_W-1:0]         tago_reg;
    logic                     dego_reg;
    coef_t                    coef_reg [0:NLANE-1];

    // stage 3 combinational
    logic signed [AREA_W-1:0] area;
    logic [DEN_W-1:0]         den_mag;
    logic signed [NUM_W-1:0]  num_s [0:NLANE-1];
    logic [NUM_W-1:0]         num_mag [0:NLANE-1];
    logic [NLANE-1:0]         neg_next;
    logic [NLANE-1:0]         ovf_next;

    // divider step combinational
    logic [REM_W-1:0]         trial [0:NSTEP-1][0:NLANE-1];
    logic [REM_W-1:0]         rem_next [0:NSTEP-1][0:NLANE-1];
    logic                     qbit [0:NSTEP-1][0:NLANE-1];

    coef_t                    coef_next [0:NLANE-1];

    assign en       = !(vo_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        area = AREA_W'(crs_reg[0]) + AREA_W'(crs_reg[1]) + AREA_W'(crs_reg[2]);
        if (area < 0)
        begin
            den_mag = DEN_W'(-area);
        end
        else
        begin
            den_mag = DEN_W'(area);
        end
        for (int l = 0; l < NLANE; l++)
        begin
            if ((l % 3) == 2)
            begin
                num_s[l] = NUM_W'(crs_reg[l/3]) <<< CSHIFT;
            end
            else
            begin
                num_s[l] = NUM_W'(dif2_reg[(l/3)*2 + (l%3)]) <<< DSHIFT;
            end
            neg_next[l] = (num_s[l] < 0) ^ (area < 0);
            if (num_s[l] < 0)
            begin
                num_mag[l] = NUM_W'(-num_s[l]);
            end
            else
            begin
                num_mag[l] = NUM_W'(num_s[l]);
            end
            ovf_next[l] = DEN_W'(num_mag[l][NUM_W-1:NSTEP]) >= den_mag;
        end
    end

    always_comb
    begin
        for (int s = 0; s < NSTEP; s++)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                trial[s][l] = {rem_reg[s][l][REM_W-2:0], sh_reg[s][l][NSTEP-1]};
                qbit[s][l]  = trial[s][l] >= {1'b0, den_reg[s]};
                if (qbit[s][l])
                begin
                    rem_next[s][l] = trial[s][l] - {1'b0, den_reg[s]};
                end
                else
                begin
                    rem_next[s][l] = trial[s][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            if (degd_reg[NSTEP])
            begin
                coef_next[l] = '0;
            end
            else if (neg_reg[NSTEP][l])
            begin
                if (ovf_reg[NSTEP][l] || quo_reg[NSTEP][l] > (NSTEP'(1) << (COEF_W-1)))
                begin
                    coef_next[l] = {1'b1, {(COEF_W-1){1'b0}}};
                end
                else
                begin
                    coef_next[l] = COEF_W'(-quo_reg[NSTEP][l]);
                end
            end
            else
            begin
                if (ovf_reg[NSTEP][l] || quo_reg[NSTEP][l][NSTEP-1:COEF_W-1] != '0)
                begin
                    coef_next[l] = {1'b0, {(COEF_W-1){1'b1}}};
                end
                else
                begin
                    coef_next[l] = COEF_W'(quo_reg[NSTEP][l]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int s = 0; s <= NSTEP; s++)
            begin
                vd_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int s = 1; s <= NSTEP; s++)
            begin
                vd_reg[s] <= vd_reg[s-1];
            end
            vo_reg <= vd_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg    <= elem_tag;
            prd_reg[0]  <= x2 * y3;
            prd_reg[1]  <= x3 * y2;
            prd_reg[2]  <= x3 * y1;
            prd_reg[3]  <= x1 * y3;
            prd_reg[4]  <= x1 * y2;
            prd_reg[5]  <= x2 * y1;
            dif1_reg[0] <= DIF_W'(y2) - DIF_W'(y3);
            dif1_reg[1] <= DIF_W'(x3) - DIF_W'(x2);
            dif1_reg[2] <= DIF_W'(y3) - DIF_W'(y1);
            dif1_reg[3] <= DIF_W'(x1) - DIF_W'(x3);
            dif1_reg[4] <= DIF_W'(y1) - DIF_W'(y2);
            dif1_reg[5] <= DIF_W'(x2) - DIF_W'(x1);

            tag2_reg   <= tag1_reg;
            dif2_reg   <= dif1_reg;
            crs_reg[0] <= CRS_W'(prd_reg[0]) - CRS_W'(prd_reg[1]);
            crs_reg[1] <= CRS_W'(prd_reg[2]) - CRS_W'(prd_reg[3]);
            crs_reg[2] <= CRS_W'(prd_reg[4]) - CRS_W'(prd_reg[5]);

            tagd_reg[0] <= tag2_reg;
            degd_reg[0] <= (area == 0);
            den_reg[0]  <= den_mag;
            neg_reg[0]  <= neg_next;
            ovf_reg[0]  <= ovf_next;
            for (int l = 0; l < NLANE; l++)
            begin
                rem_reg[0][l] <= REM_W'(num_mag[l][NUM_W-1:NSTEP]);
                sh_reg[0][l]  <= num_mag[l][NSTEP-1:0];
                quo_reg[0][l] <= '0;
            end

            for (int s = 1; s <= NSTEP; s++)
            begin
                tagd_reg[s] <= tagd_reg[s-1];
                degd_reg[s] <= degd_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                for (int l = 0; l < NLANE; l++)
                begin
                    rem_reg[s][l] <= rem_next[s-1][l];
                    sh_reg[s][l]  <= {sh_reg[s-1][l][NSTEP-2:0], 1'b0};
                    quo_reg[s][l] <= {quo_reg[s-1][l][NSTEP-2:0], qbit[s-1][l]};
                end
            end

            tago_reg <= tagd_reg[NSTEP];
            dego_reg <= degd_reg[NSTEP];
            coef_reg <= coef_next;
        end
    end

    assign out_valid    = vo_reg;
    assign elem_tag_out = tago_reg;
    assign degenerate   = dego_reg;
    assign grad_x_one   = coef_reg[0];
    assign grad_y_one   = coef_reg[1];
    assign offset_one   = coef_reg[2];
    assign grad_x_two   = coef_reg[3];
    assign grad_y_two   = coef_reg[4];
    assign offset_two   = coef_reg[5];
    assign grad_x_three = coef_reg[6];
    assign grad_y_three = coef_reg[7];
    assign offset_three = coef_reg[8];

endmodule
